@@ sv/wtrm_pkg.sv @@
// Shared types and constants for the window tile residency manager.
package wtrm_pkg;

  localparam int IDX_W          = 24;
  localparam int POS_W          = 32;
  localparam int SIZE_W         = 13;
  localparam int RADIUS_W       = 2;
  localparam int CFG_W          = 13;
  localparam int NUM_W          = 34;  // 2*pos + size, signed
  localparam int TILE_W         = 2 * IDX_W;

  localparam int DEF_TABLE_DEPTH   = 25;
  localparam int DEF_MAX_RADIUS    = 2;
  localparam int DEF_FRACTION_BITS = 8;

  localparam logic [SIZE_W-1:0]   TILE_SIZE_RST = 13'd64;
  localparam logic [RADIUS_W-1:0] RADIUS_RST    = 2'd1;

  localparam logic REG_TILE_SIZE = 1'b0;
  localparam logic REG_RADIUS    = 1'b1;

  localparam logic EV_UNLOAD = 1'b0;
  localparam logic EV_LOAD   = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIVX,
    ST_DIVZ,
    ST_UNRD,
    ST_UNEV,
    ST_CPRD,
    ST_CPEV,
    ST_WALK,
    ST_FLUSH
  } state_e;

endpackage

@@ sv/wtrm_div.sv @@
// Bit-serial floor divider: q = floor(n / d), wrapped to the tile index width.
module wtrm_div #(
  parameter int DW = 22
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic signed [wtrm_pkg::NUM_W-1:0] num_i,
  input  logic [DW-1:0]                    den_i,
  output logic                             busy_o,
  output logic                             done_o,
  output logic [wtrm_pkg::IDX_W-1:0]       quo_o
);
  localparam int NW = wtrm_pkg::NUM_W;
  localparam int CNW = $clog2(NW);

  logic          busy_q, busy_d, done_q, done_d, neg_q, neg_d;
  logic [CNW-1:0] cnt_q, cnt_d;
  logic [NW-1:0] a_q, a_d, quo_q, quo_d;
  logic [DW-1:0] rem_q, rem_d, den_q, den_d;
  logic [DW:0]   trial;

  // Negative numerator: floor(n/d) = ~floor(~n/d).
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    neg_d  = neg_q;
    cnt_d  = cnt_q;
    a_d    = a_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    trial  = {rem_q, a_q[NW-1]};
    if (start_i) begin
      busy_d = 1'b1;
      neg_d  = num_i[NW-1];
      a_d    = num_i[NW-1] ? ~num_i : num_i;
      den_d  = den_i;
      rem_d  = '0;
      quo_d  = '0;
      cnt_d  = '0;
    end else if (busy_q) begin
      a_d = {a_q[NW-2:0], 1'b0};
      if (trial >= {1'b0, den_q}) begin
        rem_d = DW'(trial - {1'b0, den_q});
        quo_d = {quo_q[NW-2:0], 1'b1};
      end else begin
        rem_d = trial[DW-1:0];
        quo_d = {quo_q[NW-2:0], 1'b0};
      end
      if (cnt_q == CNW'(NW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
      cnt_d = cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    a_q   <= a_d;
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quo_o  = neg_q ? ~quo_q[wtrm_pkg::IDX_W-1:0] : quo_q[wtrm_pkg::IDX_W-1:0];

endmodule

@@ sv/wtrm_table.sv @@
// Resident tile table: one write port, one registered read port.
module wtrm_table #(
  parameter int DEPTH = 25,
  parameter int AW    = 5
) (
  input  logic                          clk_i,
  input  logic                          rd_en_i,
  input  logic [AW-1:0]                 rd_addr_i,
  output logic [wtrm_pkg::TILE_W-1:0]   rd_data_o,
  input  logic                          wr_en_i,
  input  logic [AW-1:0]                 wr_addr_i,
  input  logic [wtrm_pkg::TILE_W-1:0]   wr_data_i
);
  logic [wtrm_pkg::TILE_W-1:0] mem [DEPTH];
  logic [wtrm_pkg::TILE_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ sv/window_tile_residency_manager_core.sv @@
// Window tile residency manager top level: sequencer, config and event output.
// Sequence: two serial divisions (x, then z); with the centre tile unchanged
//   that is all; on a change an unload scan and a compaction pass over the
//   resident tiles follow, then a walk over every window position.
// Throughput: one word at a time; in_ready_o is high only while idle. The
//   shared bit-serial divider sets the floor of the per-word cost.
// Reset: config to tile_size 64, radius 1; table empty, no centre yet.
module window_tile_residency_manager_core #(
  parameter int TABLE_DEPTH   = wtrm_pkg::DEF_TABLE_DEPTH,
  parameter int MAX_RADIUS    = wtrm_pkg::DEF_MAX_RADIUS,
  parameter int FRACTION_BITS = wtrm_pkg::DEF_FRACTION_BITS
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic                                cfg_idx_i,
  input  logic [wtrm_pkg::CFG_W-1:0]          cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [wtrm_pkg::POS_W-1:0]   pos_x_i,
  input  logic signed [wtrm_pkg::POS_W-1:0]   pos_z_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                event_kind_o,
  output logic signed [wtrm_pkg::IDX_W-1:0]   tile_x_o,
  output logic signed [wtrm_pkg::IDX_W-1:0]   tile_z_o,
  output logic                                last_event_o
);
  localparam int IW   = wtrm_pkg::IDX_W;
  localparam int SW   = wtrm_pkg::SIZE_W + FRACTION_BITS;  // size in fixed point
  localparam int DW   = SW + 1;                            // divisor 2*size
  localparam int AW   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW   = $clog2(TABLE_DEPTH + 1);
  localparam int WIN  = 2 * MAX_RADIUS + 1;
  localparam int WCW  = (WIN > 1) ? $clog2(WIN) : 1;
  localparam int NWIN = WIN * WIN;
  localparam int BIW  = (NWIN > 1) ? $clog2(NWIN) : 1;

  wtrm_pkg::state_e state_q, state_d;

  // config registers
  logic [wtrm_pkg::SIZE_W-1:0]   size_q;
  logic [wtrm_pkg::RADIUS_W-1:0] radius_q;

  // working registers
  logic [wtrm_pkg::POS_W-1:0] posz_q, posz_d;
  logic [IW-1:0]  nx_q, nx_d, cx_q, cx_d, cz_q, cz_d;
  logic           started_q, started_d;
  logic [CW-1:0]  count_q, count_d, idx_q, idx_d, wr_q, wr_d;
  logic [NWIN-1:0] bmap_q, bmap_d;
  logic [WCW-1:0] wx_q, wx_d, wz_q, wz_d;

  // pending event (held back until we know whether it is the last one)
  logic           pend_v_q, pend_v_d, pend_k_q, pend_k_d;
  logic [IW-1:0]  pend_x_q, pend_x_d, pend_z_q, pend_z_d;

  // output register
  logic           out_v_q, out_v_d, out_k_q, out_k_d, out_l_q, out_l_d;
  logic [IW-1:0]  out_x_q, out_x_d, out_z_q, out_z_d;

  // divider
  logic                                div_start, div_busy, div_done;
  logic signed [wtrm_pkg::NUM_W-1:0]   div_num;
  logic [DW-1:0]                       div_den;
  logic [IW-1:0]                       div_quo;
  logic [wtrm_pkg::POS_W-1:0]          div_pos;

  // table
  logic                        rd_en, wr_en;
  logic [AW-1:0]               rd_addr, wr_addr;
  logic [wtrm_pkg::TILE_W-1:0] rd_data, wr_data;

  // effective config
  logic [wtrm_pkg::SIZE_W-1:0]   size_eff;
  logic [wtrm_pkg::RADIUS_W-1:0] r_eff;
  logic [SW-1:0]                 size_fx;

  assign size_eff = (size_q == '0) ? wtrm_pkg::SIZE_W'(1) : size_q;
  assign r_eff    = (radius_q > wtrm_pkg::RADIUS_W'(MAX_RADIUS)) ?
                    wtrm_pkg::RADIUS_W'(MAX_RADIUS) : radius_q;
  assign size_fx  = SW'(size_eff) << FRACTION_BITS;
  assign div_den  = {size_fx, 1'b0};
  // n = 2*pos + size, exact in 34 bits
  assign div_num  = $signed({div_pos[wtrm_pkg::POS_W-1], div_pos, 1'b0})
                  + $signed({{(wtrm_pkg::NUM_W - SW){1'b0}}, size_fx});

  // window test on the table word being read
  logic [IW-1:0]        dx, dz;
  logic signed [IW-1:0] rs;
  logic                 in_win;
  logic [WCW-1:0]       lx, lz;
  logic [BIW-1:0]       tbl_bit, walk_bit;

  assign dx     = rd_data[wtrm_pkg::TILE_W-1:IW] - cx_q;
  assign dz     = rd_data[IW-1:0] - cz_q;
  assign rs     = $signed({{(IW - wtrm_pkg::RADIUS_W){1'b0}}, r_eff});
  assign in_win = ($signed(dx) >= -rs) && ($signed(dx) <= rs)
               && ($signed(dz) >= -rs) && ($signed(dz) <= rs);
  assign lx     = WCW'(dx + IW'(r_eff));
  assign lz     = WCW'(dz + IW'(r_eff));
  assign tbl_bit  = BIW'(int'(lz) * WIN + int'(lx));
  assign walk_bit = BIW'(int'(wz_q) * WIN + int'(wx_q));

  // tile visited by the load walk
  logic [IW-1:0] walk_x, walk_z;
  logic [WCW-1:0] wlast;
  assign walk_x = cx_q + IW'(wx_q) - IW'(r_eff);
  assign walk_z = cz_q + IW'(wz_q) - IW'(r_eff);
  assign wlast  = WCW'({r_eff, 1'b0});

  logic slot_free, can_push;
  assign slot_free = !out_v_q || out_ready_i;
  assign can_push  = !pend_v_q || slot_free;

  logic unload_hit, load_hit;
  assign unload_hit = !in_win;
  assign load_hit   = !bmap_q[walk_bit] && (count_q < CW'(TABLE_DEPTH));

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      wtrm_pkg::ST_IDLE: if (in_valid_i) state_d = wtrm_pkg::ST_DIVX;
      wtrm_pkg::ST_DIVX: if (div_done) state_d = wtrm_pkg::ST_DIVZ;
      wtrm_pkg::ST_DIVZ: begin
        if (div_done) begin
          if (started_q && nx_q == cx_q && div_quo == cz_q) state_d = wtrm_pkg::ST_IDLE;
          else state_d = wtrm_pkg::ST_UNRD;
        end
      end
      wtrm_pkg::ST_UNRD: state_d = (idx_q == '0) ? wtrm_pkg::ST_CPRD : wtrm_pkg::ST_UNEV;
      wtrm_pkg::ST_UNEV: if (!unload_hit || can_push) state_d = wtrm_pkg::ST_UNRD;
      wtrm_pkg::ST_CPRD: state_d = (idx_q == count_q) ? wtrm_pkg::ST_WALK : wtrm_pkg::ST_CPEV;
      wtrm_pkg::ST_CPEV: state_d = wtrm_pkg::ST_CPRD;
      wtrm_pkg::ST_WALK: begin
        if ((!load_hit || can_push) && wx_q == wlast && wz_q == wlast)
          state_d = wtrm_pkg::ST_FLUSH;
      end
      wtrm_pkg::ST_FLUSH: if (!pend_v_q || slot_free) state_d = wtrm_pkg::ST_IDLE;
      default: state_d = wtrm_pkg::ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    logic push, push_k, flush;
    logic [IW-1:0] push_x, push_z;
    posz_d = posz_q; nx_d = nx_q; cx_d = cx_q; cz_d = cz_q;
    started_d = started_q; count_d = count_q; idx_d = idx_q; wr_d = wr_q;
    bmap_d = bmap_q; wx_d = wx_q; wz_d = wz_q;
    pend_v_d = pend_v_q; pend_k_d = pend_k_q; pend_x_d = pend_x_q; pend_z_d = pend_z_q;
    out_v_d = out_v_q && !out_ready_i;
    out_k_d = out_k_q; out_l_d = out_l_q; out_x_d = out_x_q; out_z_d = out_z_q;
    div_start = 1'b0; div_pos = pos_x_i;
    rd_en = 1'b0; rd_addr = '0;
    wr_en = 1'b0; wr_addr = '0; wr_data = rd_data;
    push = 1'b0; push_k = wtrm_pkg::EV_UNLOAD; push_x = '0; push_z = '0;
    flush = 1'b0;

    unique case (state_q)
      wtrm_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          posz_d    = pos_z_i;
          div_start = 1'b1;
        end
      end
      wtrm_pkg::ST_DIVX: begin
        div_pos = posz_q;
        if (div_done) begin
          nx_d      = div_quo;
          div_start = 1'b1;
        end
      end
      wtrm_pkg::ST_DIVZ: begin
        if (div_done && !(started_q && nx_q == cx_q && div_quo == cz_q)) begin
          started_d = 1'b1;
          cx_d      = nx_q;
          cz_d      = div_quo;
          idx_d     = count_q;
          bmap_d    = '0;
        end
      end
      wtrm_pkg::ST_UNRD: begin
        if (idx_q != '0) begin
          rd_en   = 1'b1;
          rd_addr = AW'(idx_q - 1'b1);
        end else begin
          wr_d = '0;
        end
      end
      wtrm_pkg::ST_UNEV: begin
        if (!unload_hit) begin
          idx_d = idx_q - 1'b1;
        end else if (can_push) begin
          idx_d  = idx_q - 1'b1;
          push   = 1'b1;
          push_k = wtrm_pkg::EV_UNLOAD;
          push_x = rd_data[wtrm_pkg::TILE_W-1:IW];
          push_z = rd_data[IW-1:0];
        end
      end
      wtrm_pkg::ST_CPRD: begin
        if (idx_q == count_q) begin
          count_d = wr_q;
          wx_d    = '0;
          wz_d    = '0;
        end else begin
          rd_en   = 1'b1;
          rd_addr = AW'(idx_q);
        end
      end
      wtrm_pkg::ST_CPEV: begin
        idx_d = idx_q + 1'b1;
        if (in_win) begin
          wr_en            = 1'b1;
          wr_addr          = AW'(wr_q);
          wr_d             = wr_q + 1'b1;
          bmap_d[tbl_bit]  = 1'b1;
        end
      end
      wtrm_pkg::ST_WALK: begin
        if (!load_hit || can_push) begin
          if (load_hit) begin
            wr_en   = 1'b1;
            wr_addr = AW'(count_q);
            wr_data = {walk_x, walk_z};
            count_d = count_q + 1'b1;
            push    = 1'b1;
            push_k  = wtrm_pkg::EV_LOAD;
            push_x  = walk_x;
            push_z  = walk_z;
          end
          if (wx_q == wlast) begin
            wx_d = '0;
            wz_d = wz_q + 1'b1;
          end else begin
            wx_d = wx_q + 1'b1;
          end
        end
      end
      wtrm_pkg::ST_FLUSH: begin
        if (pend_v_q && slot_free) flush = 1'b1;
      end
      default: ;
    endcase

    // a new event moves the held one to the output, marked not last
    if (push) begin
      if (pend_v_q) begin
        out_v_d = 1'b1;
        out_k_d = pend_k_q;
        out_x_d = pend_x_q;
        out_z_d = pend_z_q;
        out_l_d = 1'b0;
      end
      pend_v_d = 1'b1;
      pend_k_d = push_k;
      pend_x_d = push_x;
      pend_z_d = push_z;
    end
    if (flush) begin
      out_v_d  = 1'b1;
      out_k_d  = pend_k_q;
      out_x_d  = pend_x_q;
      out_z_d  = pend_z_q;
      out_l_d  = 1'b1;
      pend_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= wtrm_pkg::ST_IDLE;
      size_q    <= wtrm_pkg::TILE_SIZE_RST;
      radius_q  <= wtrm_pkg::RADIUS_RST;
      started_q <= 1'b0;
      count_q   <= '0;
      cx_q      <= '0;
      cz_q      <= '0;
      pend_v_q  <= 1'b0;
      out_v_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      started_q <= started_d;
      count_q   <= count_d;
      cx_q      <= cx_d;
      cz_q      <= cz_d;
      pend_v_q  <= pend_v_d;
      out_v_q   <= out_v_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          wtrm_pkg::REG_TILE_SIZE: size_q   <= cfg_data_i[wtrm_pkg::SIZE_W-1:0];
          wtrm_pkg::REG_RADIUS:    radius_q <= cfg_data_i[wtrm_pkg::RADIUS_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    posz_q   <= posz_d;
    nx_q     <= nx_d;
    idx_q    <= idx_d;
    wr_q     <= wr_d;
    bmap_q   <= bmap_d;
    wx_q     <= wx_d;
    wz_q     <= wz_d;
    pend_k_q <= pend_k_d;
    pend_x_q <= pend_x_d;
    pend_z_q <= pend_z_d;
    out_k_q  <= out_k_d;
    out_l_q  <= out_l_d;
    out_x_q  <= out_x_d;
    out_z_q  <= out_z_d;
  end

  wtrm_div #(
    .DW(DW)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_num),
    .den_i  (div_den),
    .busy_o (div_busy),
    .done_o (div_done),
    .quo_o  (div_quo)
  );

  wtrm_table #(
    .DEPTH(TABLE_DEPTH),
    .AW   (AW)
  ) u_table (
    .clk_i    (clk_i),
    .rd_en_i  (rd_en),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_data)
  );

  assign in_ready_o   = (state_q == wtrm_pkg::ST_IDLE);
  assign out_valid_o  = out_v_q;
  assign event_kind_o = out_k_q;
  assign tile_x_o     = out_x_q;
  assign tile_z_o     = out_z_q;
  assign last_event_o = out_l_q;

  // no event may be left held back once the block is idle again
  a_idle_no_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !pend_v_q) else $error("held event left while idle");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(TABLE_DEPTH)) else $error("resident count overflow");

  a_div_owner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_busy |-> (state_q == wtrm_pkg::ST_DIVX || state_q == wtrm_pkg::ST_DIVZ))
    else $error("divider busy outside division states");

  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == wtrm_pkg::ST_FLUSH && pend_v_q && slot_free) |=> (out_v_q && out_l_q))
    else $error("final word not marked last");

endmodule

@@ test/window_tile_residency_manager_core_tb.sv @@
// Self-checking testbench for the window tile residency manager core.
`timescale 1ns / 1ps

module window_tile_residency_manager_core_tb;

  localparam int FRAC       = wtrm_pkg::DEF_FRACTION_BITS;
  localparam int DEPTH      = wtrm_pkg::DEF_TABLE_DEPTH;
  localparam int RMAX       = wtrm_pkg::DEF_MAX_RADIUS;
  localparam int DRAIN_WAIT = 400;  // quiet cycles once the block is idle
  localparam int HOLD_LEN   = 600;

  typedef struct packed {
    logic signed [wtrm_pkg::POS_W-1:0] x;
    logic signed [wtrm_pkg::POS_W-1:0] z;
  } pos_t;

  typedef struct packed {
    logic                       kind;
    logic [wtrm_pkg::IDX_W-1:0] tx;
    logic [wtrm_pkg::IDX_W-1:0] tz;
    logic                       last;
  } tile_event_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic cfg_idx_i = wtrm_pkg::REG_TILE_SIZE;
  logic [wtrm_pkg::CFG_W-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic signed [wtrm_pkg::POS_W-1:0] pos_x_i = '0;
  logic signed [wtrm_pkg::POS_W-1:0] pos_z_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic event_kind_o;
  logic signed [wtrm_pkg::IDX_W-1:0] tile_x_o;
  logic signed [wtrm_pkg::IDX_W-1:0] tile_z_o;
  logic last_event_o;

  window_tile_residency_manager_core i_dut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Mirror of the block: config, resident table, centre.
  logic [wtrm_pkg::SIZE_W-1:0]   cur_size = wtrm_pkg::TILE_SIZE_RST;
  logic [wtrm_pkg::RADIUS_W-1:0] cur_radius = wtrm_pkg::RADIUS_RST;
  logic [wtrm_pkg::TILE_W-1:0]   table_q[$];  // {x, z}, in table order
  logic [wtrm_pkg::IDX_W-1:0]    ctr_x = '0;
  logic [wtrm_pkg::IDX_W-1:0]    ctr_z = '0;
  bit                            have_ctr = 0;

  pos_t        pending_pos[$];  // words still to offer
  tile_event_t events_due[$];   // predicted events in order
  int send_idle_pct = 0, recv_stall_pct = 0;
  int hold_req = 0;
  int errors = 0, words_sent = 0, events_seen = 0, loads_seen = 0, unloads_seen = 0;

  task automatic queue_pos(pos_t p);
    pending_pos.insert(pending_pos.size(), p);
  endtask

  // floor((2*pos + S) / (2*S)) with S the size in fixed point, kept to 24 bits
  function automatic logic [wtrm_pkg::IDX_W-1:0] tile_of(
      logic signed [wtrm_pkg::POS_W-1:0] p, logic [wtrm_pkg::SIZE_W-1:0] sz);
    longint s, n, d, q;
    s = longint'(sz == 0 ? 1 : sz) << FRAC;
    n = 2 * longint'(p) + s;
    d = 2 * s;
    q = n / d;
    if (n % d < 0) q = q - 1;
    return q[wtrm_pkg::IDX_W-1:0];
  endfunction

  function automatic bit near_ctr(logic [wtrm_pkg::TILE_W-1:0] t, int r);
    logic signed [wtrm_pkg::IDX_W-1:0] dx, dz;
    dx = t[wtrm_pkg::TILE_W-1:wtrm_pkg::IDX_W] - ctr_x;
    dz = t[wtrm_pkg::IDX_W-1:0] - ctr_z;
    return int'(dx) >= -r && int'(dx) <= r && int'(dz) >= -r && int'(dz) <= r;
  endfunction

  task automatic predict_events(pos_t p);
    logic [wtrm_pkg::IDX_W-1:0]  nx, nz;
    logic [wtrm_pkg::TILE_W-1:0] kept[$];
    logic [wtrm_pkg::TILE_W-1:0] t;
    tile_event_t                 ev[$];
    int r;
    bit found;
    r  = cur_radius > RMAX ? RMAX : int'(cur_radius);
    nx = tile_of(p.x, cur_size);
    nz = tile_of(p.z, cur_size);
    if (have_ctr && nx == ctr_x && nz == ctr_z) return;
    have_ctr = 1;
    ctr_x = nx;
    ctr_z = nz;
    // unload scan runs last to first; the table keeps its order
    for (int i = table_q.size() - 1; i >= 0; i--)
      if (!near_ctr(table_q[i], r))
        ev.insert(ev.size(), '{wtrm_pkg::EV_UNLOAD,
                               table_q[i][wtrm_pkg::TILE_W-1:wtrm_pkg::IDX_W],
                               table_q[i][wtrm_pkg::IDX_W-1:0], 1'b0});
    foreach (table_q[i])
      if (near_ctr(table_q[i], r)) kept.insert(kept.size(), table_q[i]);
    table_q = kept;
    // load walk: z outer, x inner, ascending
    for (int dz = -r; dz <= r; dz++)
      for (int dx = -r; dx <= r; dx++) begin
        t = {ctr_x + wtrm_pkg::IDX_W'(dx), ctr_z + wtrm_pkg::IDX_W'(dz)};
        found = 0;
        foreach (table_q[i]) if (table_q[i] == t) found = 1;
        if (!found && table_q.size() < DEPTH) begin
          table_q.insert(table_q.size(), t);
          ev.insert(ev.size(), '{wtrm_pkg::EV_LOAD, t[wtrm_pkg::TILE_W-1:wtrm_pkg::IDX_W],
                                 t[wtrm_pkg::IDX_W-1:0], 1'b0});
        end
      end
    if (ev.size() > 0) ev[ev.size()-1].last = 1'b1;
    foreach (ev[i]) events_due.insert(events_due.size(), ev[i]);
  endtask

  // Driver: predicts on acceptance, then offers the next word or idles.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        predict_events('{pos_x_i, pos_z_i});
        words_sent++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (pending_pos.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          pos_x_i    <= pending_pos[0].x;
          pos_z_i    <= pending_pos[0].z;
          in_valid_i <= 1'b1;
          void'(pending_pos.pop_front());
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each event word against the oldest prediction.
  int hold_seen = 0, hold_left = 0;
  always @(posedge clk_i) begin
    tile_event_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        events_seen++;
        if (event_kind_o == wtrm_pkg::EV_LOAD) loads_seen++; else unloads_seen++;
        if (events_due.size() == 0) begin
          $display("%0t: unexpected event kind %0d tile (%0d,%0d) last %0d", $time,
                   event_kind_o, tile_x_o, tile_z_o, last_event_o);
          errors++;
        end else begin
          want = events_due.pop_front();
          if (want.kind !== event_kind_o) begin
            $display("%0t: event_kind exp %0d got %0d", $time, want.kind, event_kind_o);
            errors++;
          end
          if (want.tx !== tile_x_o) begin
            $display("%0t: tile_x exp %0d got %0d", $time, $signed(want.tx), tile_x_o);
            errors++;
          end
          if (want.tz !== tile_z_o) begin
            $display("%0t: tile_z exp %0d got %0d", $time, $signed(want.tz), tile_z_o);
            errors++;
          end
          if (want.last !== last_event_o) begin
            $display("%0t: last_event exp %0d got %0d", $time, want.last, last_event_o);
            errors++;
          end
        end
      end
      // long hold-off on request, so the block backs up into its input
      if (hold_req != hold_seen) begin
        hold_seen   <= hold_req;
        hold_left   <= HOLD_LEN;
        out_ready_i <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left   <= hold_left - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= $urandom_range(0, 99) >= recv_stall_pct;
      end
    end
  end

  // Waits until nothing is in flight and the block is idle, then a quiet gap.
  task automatic wait_idle();
    @(negedge clk_i);
    while (pending_pos.size() > 0 || in_valid_i || events_due.size() > 0 || !in_ready_o)
      @(negedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [wtrm_pkg::CFG_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == wtrm_pkg::REG_TILE_SIZE) cur_size = val[wtrm_pkg::SIZE_W-1:0];
    else cur_radius = val[wtrm_pkg::RADIUS_W-1:0];
  endtask

  // Position somewhere inside tile t at the current size (wraps to 32 bits).
  function automatic logic signed [wtrm_pkg::POS_W-1:0] pos_in_tile(longint t);
    longint s;
    s = longint'(cur_size == 0 ? 1 : cur_size) << FRAC;
    return wtrm_pkg::POS_W'(t * s + longint'($urandom_range(0, s - 1)) - s / 2);
  endfunction

  // Mostly short walks between neighbouring tiles, some stays, some noise.
  task automatic queue_walk(int n);
    longint wx, wz;
    int pick;
    wx = $signed($urandom_range(0, 64)) - 32;
    wz = $signed($urandom_range(0, 64)) - 32;
    repeat (n) begin
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
        queue_pos('{$urandom(), $urandom()});
      end else begin
        if (pick >= 30) begin
          wx += $signed($urandom_range(0, 4)) - 2;
          wz += $signed($urandom_range(0, 4)) - 2;
        end
        queue_pos('{pos_in_tile(wx), pos_in_tile(wz)});
      end
    end
  endtask

  task automatic run_phase(logic [wtrm_pkg::CFG_W-1:0] sz, logic [wtrm_pkg::CFG_W-1:0] rad,
                           int idle, int stall, int n);
    wait_idle();
    write_reg(wtrm_pkg::REG_TILE_SIZE, sz);
    write_reg(wtrm_pkg::REG_RADIUS, rad);
    send_idle_pct  = idle;
    recv_stall_pct = stall;
    queue_walk(n);
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: first word, unchanged centre, single steps, tile edges,
    // field extremes; reset config (size 64, radius 1).
    queue_pos('{32'sd0, 32'sd0});
    queue_pos('{32'sd100, -32'sd100});
    queue_pos('{32'sd16384, 32'sd0});
    queue_pos('{32'sd8192, 32'sd8191});
    queue_pos('{-32'sd8192, -32'sd8193});
    queue_pos('{32'h7fffffff, 32'h80000000});
    queue_pos('{32'h80000000, 32'h7fffffff});
    queue_pos('{-32'sd1, -32'sd1});
    // size 1, radius 2: indices reach the 24-bit wrap, window straddles it
    wait_idle();
    write_reg(wtrm_pkg::REG_TILE_SIZE, 13'd1);
    write_reg(wtrm_pkg::REG_RADIUS, 13'd2);
    queue_pos('{32'h7fffffff, 32'h7fffffff});
    queue_pos('{32'h7ffffe00, 32'h80000000});
    queue_pos('{32'h80000000, 32'h80000100});
    queue_pos('{32'sd0, 32'sd0});
    // zero size acts as one; radius above the limit saturates
    wait_idle();
    write_reg(wtrm_pkg::REG_TILE_SIZE, 13'd0);
    write_reg(wtrm_pkg::REG_RADIUS, 13'd3);
    queue_pos('{32'sd256, 32'sd0});
    queue_pos('{32'sd2048, -32'sd2048});
    queue_pos('{32'h7fffffff, 32'sd0});
    // largest size, radius zero
    wait_idle();
    write_reg(wtrm_pkg::REG_TILE_SIZE, 13'h1fff);
    write_reg(wtrm_pkg::REG_RADIUS, 13'd0);
    queue_pos('{32'h7fffffff, 32'h80000000});
    queue_pos('{32'sd0, 32'sd0});
    queue_pos('{32'h80000000, 32'sd0});

    // Random walks across settings and idling mixes.
    run_phase(13'd64, 13'd1, 0, 0, 45);
    run_phase(13'd1, 13'd2, 82, 0, 45);
    run_phase(13'd4096, 13'd0, 0, 82, 40);
    run_phase(13'd7, 13'd2, 35, 35, 45);
    // receiver holds off long while the sender keeps offering
    run_phase(13'd3, 13'd2, 0, 0, 30);
    hold_req = hold_req + 1;
    // sender waits for every result before the last batch
    wait_idle();
    run_phase(13'd0, 13'd1, 35, 35, 60);

    wait_idle();
    $display("Run: %0d position words over sizes 0..8191 and radius 0..3", words_sent);
    $display("Events checked: %0d (%0d loads, %0d unloads)", events_seen, loads_seen,
             unloads_seen);
    if (errors == 0) begin
      $display("window_tile_residency_manager_core_tb OK");
    end else begin
      $display("window_tile_residency_manager_core_tb NOT OK");
    end
    $finish;
  end

  initial begin
    #8000000;
    $display("window_tile_residency_manager_core_tb NOT OK");
    $finish;
  end

endmodule
